>>> hw/rtl/qcsn_pkg.sv
// Shared types, codes and helpers of the quick charge sink negotiator.
// Depends on nothing; the top level imports it.
`timescale 1ns / 1ps

package qcsn_pkg;

    // Width of the millisecond delay counter.
    localparam int DELAY_BITS = 12;

    // Width of the widest configuration register and of the write port.
    localparam int CFG_WIDTH  = 12;
    localparam int ADDR_WIDTH = 3;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;
    localparam int EXT_W = (CFG_WIDTH > DELAY_BITS) ? CFG_WIDTH : DELAY_BITS;

    // Configuration register indexes.
    localparam logic [ADDR_WIDTH-1:0] REG_HOLD   = 3'd0;
    localparam logic [ADDR_WIDTH-1:0] REG_SETTLE = 3'd1;
    localparam logic [ADDR_WIDTH-1:0] REG_ENTRY  = 3'd2;
    localparam logic [ADDR_WIDTH-1:0] REG_PULSE  = 3'd3;
    localparam logic [ADDR_WIDTH-1:0] REG_GUARD  = 3'd4;

    // Register reset values.
    localparam logic [11:0] HOLD_RESET   = 12'd1500;
    localparam logic [7:0]  SETTLE_RESET = 8'd3;
    localparam logic [7:0]  ENTRY_RESET  = 8'd60;
    localparam logic [3:0]  PULSE_RESET  = 4'd1;
    localparam logic [7:0]  GUARD_RESET  = 8'd50;

    typedef enum logic [1:0] {
        LV_0V  = 2'd0,
        LV_06V = 2'd1,
        LV_33V = 2'd2
    } level_t;

    typedef enum logic [2:0] {
        CHG_OFF  = 3'd0,
        CHG_MAN  = 3'd1,
        CHG_5V   = 3'd2,
        CHG_9V   = 3'd3,
        CHG_12V  = 3'd4,
        CHG_20V  = 3'd5,
        CHG_CONT = 3'd6
    } chg_t;

    typedef enum logic [4:0] {
        CMD_DISABLE  = 5'd0,
        CMD_SET_5V   = 5'd1,
        CMD_SET_9V   = 5'd2,
        CMD_SET_12V  = 5'd3,
        CMD_SET_20V  = 5'd4,
        CMD_INIT_5V  = 5'd5,
        CMD_INIT_9V  = 5'd6,
        CMD_CONT     = 5'd7,
        CMD_RAISE    = 5'd8,
        CMD_LOWER    = 5'd9,
        CMD_PROBE    = 5'd10,
        CMD_DP_0V    = 5'd11,
        CMD_DP_06V   = 5'd12,
        CMD_DP_33V   = 5'd13,
        CMD_DM_0V    = 5'd14,
        CMD_DM_06V   = 5'd15,
        CMD_DM_33V   = 5'd16
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE        = 5'd0,
        S_INIT5_DP    = 5'd1,
        S_INIT5_DM    = 5'd2,
        S_INIT9_DP    = 5'd3,
        S_INIT9_DM    = 5'd4,
        S_CONT_DM     = 5'd5,
        S_CONT_ENTRY  = 5'd6,
        S_RAISE_HI    = 5'd7,
        S_RAISE_LO    = 5'd8,
        S_LOWER_LO    = 5'd9,
        S_LOWER_HI    = 5'd10,
        S_PRB_GUARD   = 5'd11,
        S_PRB_SAMPLE1 = 5'd12,
        S_PRB_HOLD    = 5'd13,
        S_PRB_SAMPLE2 = 5'd14,
        S_PRB_RELEASE = 5'd15,
        S_PRB_END     = 5'd16
    } step_t;

    // A zero delay counts as one millisecond; a delay beyond the counter saturates.
    function automatic logic [DELAY_BITS-1:0] load_delay(input logic [CFG_WIDTH-1:0] v);
        logic [EXT_W-1:0] ext;
        logic [DELAY_BITS-1:0] res;
        ext = EXT_W'(v);
        if (ext == '0)
            res = DELAY_BITS'(1);
        else if (ext > EXT_W'(DELAY_MAX))
            res = DELAY_MAX;
        else
            res = DELAY_BITS'(ext);
        return res;
    endfunction

endpackage

>>> hw/rtl/quick_charge_sink_negotiator.sv
// Quick Charge 3 sink negotiator: top level with line sequencer and result register.
// Depends on qcsn_pkg for codes, types and the delay load helper.
`timescale 1ns / 1ps

// The result of an input transaction is registered and appears on the master side in the next cycle.
// Throughput: one input transaction per cycle while the master side takes results; the state
// update for one item is a single pass through the command decoder and the sequence step logic.
// The output register frees itself in the same cycle it is taken, so a stall on the
// master side holds the slave side only while a result is waiting.
// Reset (rst_n low, asynchronous) sets both lines to 0 V, D- driven, charger off,
// no sequence running, and the timing registers to their default values.
module quick_charge_sink_negotiator
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Slave side: tick or command items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: command [4:0], dm_sense [5], zero [7:6].
    input  logic [qcsn_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: mode (0 millisecond tick, 1 command).
    input  logic                                s_tuser,
    // Master side: one result per item.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: dp_level [1:0], dm_level [3:2], dm_drive_enable [4], charger_state [7:5],
    // busy_res [8], command_rejected [9], probe_done [10], qc_supported [11],
    // zero [15:12].
    output logic [qcsn_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [qcsn_pkg::ADDR_WIDTH-1:0]     cfg_addr,
    input  logic [qcsn_pkg::CFG_WIDTH-1:0]      cfg_wdata
);
    import qcsn_pkg::*;

    // Timing registers.
    logic [11:0] hold_reg;
    logic [7:0]  settle_reg;
    logic [7:0]  entry_reg;
    logic [3:0]  pulse_reg;
    logic [7:0]  guard_reg;

    // Sequencer and line state.
    step_t                 step_reg,  step_next;
    logic [DELAY_BITS-1:0] delay_reg, delay_next;
    level_t                dp_reg,    dp_next;
    level_t                dm_reg,    dm_next;
    chg_t                  chg_reg,   chg_next;
    logic                  float_reg, float_next;
    logic                  fsh_reg,   fsh_next;

    // Result register.
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic                  accept;
    logic                  mode;
    cmd_t                  cmd;
    logic                  sense;
    logic                  busy;
    logic                  start;
    logic                  expire;
    logic                  count_down;
    logic                  rejected;
    logic                  done;

    // The slave side is ready whenever the result register is empty or being emptied.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign mode  = s_tuser;
    assign cmd   = cmd_t'(s_tdata[4:0]);
    assign sense = s_tdata[5];

    // A sequence is running whenever the step is not idle. Commands are started only
    // when idle; a tick moves a running sequence on once its current wait has expired.
    assign busy       = (step_reg != S_IDLE);
    assign start      = accept && mode && !busy;
    assign count_down = accept && !mode && busy && (delay_reg > DELAY_BITS'(1));
    assign expire     = accept && !mode && busy && !(delay_reg > DELAY_BITS'(1));

    // Configuration writes; indexes outside the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= HOLD_RESET;
            settle_reg <= SETTLE_RESET;
            entry_reg  <= ENTRY_RESET;
            pulse_reg  <= PULSE_RESET;
            guard_reg  <= GUARD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_HOLD:   hold_reg   <= cfg_wdata[11:0];
                REG_SETTLE: settle_reg <= cfg_wdata[7:0];
                REG_ENTRY:  entry_reg  <= cfg_wdata[7:0];
                REG_PULSE:  pulse_reg  <= cfg_wdata[3:0];
                REG_GUARD:  guard_reg  <= cfg_wdata[7:0];
                default:    ;
            endcase
        end
    end

    // Next state: sequence step and millisecond counter.
    always_comb
    begin
        step_next  = step_reg;
        delay_next = delay_reg;
        if (start)
        begin
            case (cmd)
                CMD_INIT_5V:
                begin
                    step_next  = S_INIT5_DP;
                    delay_next = load_delay(hold_reg);
                end
                CMD_INIT_9V:
                begin
                    step_next  = S_INIT9_DP;
                    delay_next = load_delay(hold_reg);
                end
                CMD_CONT:
                begin
                    step_next  = S_CONT_DM;
                    delay_next = load_delay(CFG_WIDTH'(settle_reg));
                end
                CMD_RAISE:
                begin
                    step_next  = S_RAISE_HI;
                    delay_next = load_delay(CFG_WIDTH'(pulse_reg));
                end
                CMD_LOWER:
                begin
                    step_next  = S_LOWER_LO;
                    delay_next = load_delay(CFG_WIDTH'(pulse_reg));
                end
                CMD_PROBE:
                begin
                    step_next  = S_PRB_GUARD;
                    delay_next = load_delay(CFG_WIDTH'(guard_reg));
                end
                default: ;
            endcase
        end
        else if (count_down)
        begin
            delay_next = delay_reg - DELAY_BITS'(1);
        end
        else if (expire)
        begin
            delay_next = '0;
            case (step_reg)
                S_INIT5_DP:
                begin
                    step_next  = S_INIT5_DM;
                    delay_next = load_delay(CFG_WIDTH'(settle_reg));
                end
                S_INIT9_DP:
                begin
                    step_next  = S_INIT9_DM;
                    delay_next = load_delay(CFG_WIDTH'(settle_reg));
                end
                S_CONT_DM:
                begin
                    step_next  = S_CONT_ENTRY;
                    delay_next = load_delay(CFG_WIDTH'(entry_reg));
                end
                S_RAISE_HI:
                begin
                    step_next  = S_RAISE_LO;
                    delay_next = load_delay(CFG_WIDTH'(pulse_reg));
                end
                S_LOWER_LO:
                begin
                    step_next  = S_LOWER_HI;
                    delay_next = load_delay(CFG_WIDTH'(pulse_reg));
                end
                S_PRB_GUARD:
                begin
                    step_next  = S_PRB_SAMPLE1;
                    delay_next = load_delay(CFG_WIDTH'(1));
                end
                S_PRB_SAMPLE1:
                begin
                    step_next  = S_PRB_HOLD;
                    delay_next = load_delay(hold_reg);
                end
                S_PRB_HOLD:
                begin
                    step_next  = S_PRB_SAMPLE2;
                    delay_next = load_delay(CFG_WIDTH'(1));
                end
                S_PRB_SAMPLE2:
                begin
                    step_next  = S_PRB_RELEASE;
                    delay_next = load_delay(CFG_WIDTH'(guard_reg));
                end
                S_PRB_RELEASE:
                begin
                    step_next  = S_PRB_END;
                    delay_next = load_delay(CFG_WIDTH'(1));
                end
                default: step_next = S_IDLE;
            endcase
        end
    end

    // Outputs: line levels, charger state, probe samples and per-item flags.
    always_comb
    begin
        dp_next    = dp_reg;
        dm_next    = dm_reg;
        chg_next   = chg_reg;
        float_next = float_reg;
        fsh_next   = fsh_reg;
        rejected   = accept && mode && busy;
        done       = 1'b0;
        if (start)
        begin
            case (cmd)
                CMD_DISABLE:
                begin
                    dp_next = LV_06V; dm_next = LV_0V;  chg_next = CHG_OFF;
                end
                CMD_SET_5V:
                begin
                    dp_next = LV_06V; dm_next = LV_0V;  chg_next = CHG_5V;
                end
                CMD_SET_9V:
                begin
                    dp_next = LV_33V; dm_next = LV_06V; chg_next = CHG_9V;
                end
                CMD_SET_12V:
                begin
                    dp_next = LV_06V; dm_next = LV_06V; chg_next = CHG_12V;
                end
                CMD_SET_20V:
                begin
                    dp_next = LV_33V; dm_next = LV_33V; chg_next = CHG_20V;
                end
                CMD_INIT_5V, CMD_DP_06V:
                begin
                    dp_next = LV_06V; chg_next = CHG_MAN;
                end
                CMD_INIT_9V, CMD_RAISE, CMD_DP_33V:
                begin
                    dp_next = LV_33V; chg_next = CHG_MAN;
                end
                CMD_CONT, CMD_DM_33V:
                begin
                    dm_next = LV_33V; chg_next = CHG_MAN;
                end
                CMD_LOWER, CMD_DM_06V:
                begin
                    dm_next = LV_06V; chg_next = CHG_MAN;
                end
                CMD_PROBE:
                begin
                    float_next = 1'b1; fsh_next = 1'b0;
                end
                CMD_DP_0V:
                begin
                    dp_next = LV_0V; chg_next = CHG_MAN;
                end
                CMD_DM_0V:
                begin
                    dm_next = LV_0V; chg_next = CHG_MAN;
                end
                default: ;
            endcase
        end
        else if (expire)
        begin
            case (step_reg)
                S_INIT5_DP:
                begin
                    dm_next = LV_0V; chg_next = CHG_MAN;
                end
                S_INIT5_DM: chg_next = CHG_5V;
                S_INIT9_DP:
                begin
                    dm_next = LV_06V; chg_next = CHG_MAN;
                end
                S_INIT9_DM: chg_next = CHG_9V;
                S_CONT_DM, S_RAISE_HI:
                begin
                    dp_next = LV_06V; chg_next = CHG_MAN;
                end
                S_LOWER_LO:
                begin
                    dm_next = LV_33V; chg_next = CHG_MAN;
                end
                S_CONT_ENTRY, S_RAISE_LO, S_LOWER_HI: chg_next = CHG_CONT;
                S_PRB_GUARD, S_PRB_HOLD:
                begin
                    dp_next = LV_33V; chg_next = CHG_MAN;
                end
                S_PRB_SAMPLE1:
                begin
                    fsh_next = sense;
                    dp_next  = LV_06V; chg_next = CHG_MAN;
                end
                S_PRB_SAMPLE2:
                begin
                    // Support needs D- high on the first sample and low on the second.
                    fsh_next   = fsh_reg & ~sense;
                    float_next = 1'b0;
                end
                S_PRB_RELEASE:
                begin
                    dp_next = LV_06V; dm_next = LV_0V; chg_next = CHG_MAN;
                end
                S_PRB_END:
                begin
                    chg_next = fsh_reg ? CHG_5V : CHG_MAN;
                    done     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= S_IDLE;
            delay_reg <= '0;
            dp_reg    <= LV_0V;
            dm_reg    <= LV_0V;
            chg_reg   <= CHG_OFF;
            float_reg <= 1'b0;
            fsh_reg   <= 1'b0;
        end
        else if (accept)
        begin
            step_reg  <= step_next;
            delay_reg <= delay_next;
            dp_reg    <= dp_next;
            dm_reg    <= dm_next;
            chg_reg   <= chg_next;
            float_reg <= float_next;
            fsh_reg   <= fsh_next;
        end
    end

    // Result register: valid is control state, the payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s_tready)
            m_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= {4'b0000,
                           done & fsh_next,
                           done,
                           rejected,
                           (step_next != S_IDLE),
                           chg_next,
                           ~float_next,
                           dm_next,
                           dp_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // D- is left floating only from probe start through the second sample.
    a_float_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
        float_reg |-> (step_reg == S_PRB_GUARD || step_reg == S_PRB_SAMPLE1 ||
                       step_reg == S_PRB_HOLD || step_reg == S_PRB_SAMPLE2))
        else $error("D- floating outside the probe window");

    // Sequencer state moves only on an accepted transaction.
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(step_reg) && $stable(delay_reg) && $stable(chg_reg)))
        else $error("sequencer state changed without a transaction");

    // A tick with time left counts the wait down by exactly one.
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        count_down |=> (delay_reg == $past(delay_reg) - DELAY_BITS'(1) &&
                        step_reg == $past(step_reg)))
        else $error("delay counter did not step down");

    // A finished probe leaves the sequencer idle with a 5 V or manual state.
    a_probe_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[10]) |->
            (!m_data_reg[8] && (m_data_reg[7:5] == CHG_5V || m_data_reg[7:5] == CHG_MAN)))
        else $error("probe result with inconsistent state");

    // Support is only reported together with probe completion.
    a_supported: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[11]) |-> (m_data_reg[10] && m_data_reg[7:5] == CHG_5V))
        else $error("support reported without a finished probe");

endmodule
